### hdl/lwsrq_pkg.sv
// Package for the leveled work-stealing ready queue.
// Holds parameter defaults, request and status codes, and the payload structs.
// Has no dependencies.
package lwsrq_pkg;

  localparam int NUM_LEVELS_DEF  = 16;
  localparam int LEVEL_DEPTH_DEF = 32;
  localparam int HANDLE_BITS_DEF = 16;

  localparam logic [1:0] REQ_POST  = 2'd0;
  localparam logic [1:0] REQ_TAKE  = 2'd1;
  localparam logic [1:0] REQ_STEAL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  level;
    logic [15:0] task_handle;
  } req_t;

  typedef struct packed {
    logic [15:0] out_handle;
    logic [3:0]  served_level;
    logic [1:0]  status;
  } rsp_t;

endpackage

### hdl/leveled_work_stealing_ready_queue.sv
// Leveled work-stealing ready queue: post to a level, take deepest, steal shallowest.
// Depends on lwsrq_pkg and lwsrq_ram. A request is taken only while the block is idle.
// Steps: accept into the request register, execute with the slot RAM access, then register the result.
// A new request is taken only after the previous one has registered its result.
// A stalled output holds the block in its final step until the result transfer.
// Reset clears all level pointers, counts and the occupancy map at once; no clearing pass.
module leveled_work_stealing_ready_queue
  import lwsrq_pkg::*;
#(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DONE} state_e;

  state_e                  state_q;
  req_t                    req_q;
  logic [PTR_W-1:0]        head_q [NUM_LEVELS];
  logic [CNT_W-1:0]        cnt_q  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0]   map_q;
  logic [3:0]              pend_lvl_q;
  logic [1:0]              pend_st_q;
  logic                    use_ram_q;
  rsp_t                    out_q;
  logic                    out_valid_q;

  logic [LVL_W-1:0]        deep_lvl, shallow_lvl, sel_lvl;
  logic [PTR_W-1:0]        sel_head, head_dec, head_inc, tail_idx, head_n, ram_idx;
  logic [CNT_W-1:0]        sel_cnt, cnt_m1, cnt_n;
  logic [PTR_W:0]          tail_sum;
  logic                    any_nonempty, in_range, lvl_full, upd, rd;
  logic                    ram_en, ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic [HANDLE_BITS-1:0]  ram_wdata, ram_rdata;
  logic [HANDLE_BITS+15:0] in_ext;
  logic [HANDLE_BITS+15:0] out_ext;
  logic [3:0]              rsp_lvl;
  logic [1:0]              rsp_st;
  logic                    in_xfer, out_free;

  always_comb begin
    deep_lvl    = '0;
    shallow_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (map_q[i]) begin
        deep_lvl = LVL_W'(i);
      end
    end
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (map_q[i]) begin
        shallow_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    case (req_q.req_type)
      REQ_POST: begin
        sel_lvl = LVL_W'(req_q.level);
      end
      REQ_TAKE: begin
        sel_lvl = deep_lvl;
      end
      default: begin
        sel_lvl = shallow_lvl;
      end
    endcase
  end

  assign any_nonempty = |map_q;
  assign in_range     = (int'(req_q.level) < NUM_LEVELS);
  assign sel_head     = head_q[sel_lvl];
  assign sel_cnt      = cnt_q[sel_lvl];
  assign lvl_full     = (sel_cnt == CNT_W'(LEVEL_DEPTH));
  assign head_dec     = (sel_head == '0) ? PTR_W'(LEVEL_DEPTH - 1) : sel_head - 1'b1;
  assign head_inc     = (sel_head == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : sel_head + 1'b1;
  assign cnt_m1       = sel_cnt - CNT_W'(1);
  assign tail_sum     = (PTR_W+1)'(sel_head) + (PTR_W+1)'(cnt_m1);
  assign tail_idx     = (tail_sum >= (PTR_W+1)'(LEVEL_DEPTH))
                        ? PTR_W'(tail_sum - (PTR_W+1)'(LEVEL_DEPTH)) : PTR_W'(tail_sum);

  always_comb begin
    ram_en  = 1'b0;
    ram_we  = 1'b0;
    ram_idx = sel_head;
    upd     = 1'b0;
    rd      = 1'b0;
    head_n  = sel_head;
    cnt_n   = sel_cnt;
    rsp_lvl = '0;
    rsp_st  = ST_EMPTY;
    case (req_q.req_type)
      REQ_POST: begin
        rsp_lvl = req_q.level;
        if (!in_range) begin
          rsp_st = ST_RANGE;
        end else if (lvl_full) begin
          rsp_st = ST_FULL;
        end else begin
          rsp_st  = ST_OK;
          upd     = 1'b1;
          head_n  = head_dec;
          cnt_n   = sel_cnt + CNT_W'(1);
          ram_en  = 1'b1;
          ram_we  = 1'b1;
          ram_idx = head_dec;
        end
      end
      REQ_TAKE: begin
        if (any_nonempty) begin
          rsp_st  = ST_OK;
          rsp_lvl = 4'(sel_lvl);
          upd     = 1'b1;
          rd      = 1'b1;
          head_n  = head_inc;
          cnt_n   = cnt_m1;
          ram_en  = 1'b1;
          ram_idx = sel_head;
        end
      end
      REQ_STEAL: begin
        if (any_nonempty) begin
          rsp_st  = ST_OK;
          rsp_lvl = 4'(sel_lvl);
          upd     = 1'b1;
          rd      = 1'b1;
          cnt_n   = cnt_m1;
          ram_en  = 1'b1;
          ram_idx = tail_idx;
        end
      end
      default: begin
      end
    endcase
    if (state_q != S_EXEC) begin
      ram_en = 1'b0;
      ram_we = 1'b0;
    end
  end

  assign ram_addr  = ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(ram_idx);
  assign in_ext    = {{HANDLE_BITS{1'b0}}, req_q.task_handle};
  assign ram_wdata = in_ext[HANDLE_BITS-1:0];
  assign out_ext   = {16'b0, ram_rdata};

  lwsrq_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      map_q       <= '0;
      pend_lvl_q  <= '0;
      pend_st_q   <= ST_EMPTY;
      use_ram_q   <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            req_q   <= in_data_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (upd) begin
            head_q[sel_lvl] <= head_n;
            cnt_q[sel_lvl]  <= cnt_n;
            map_q[sel_lvl]  <= (cnt_n != '0);
          end
          pend_lvl_q <= rsp_lvl;
          pend_st_q  <= rsp_st;
          use_ram_q  <= rd;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_q.out_handle   <= use_ram_q ? out_ext[15:0] : '0;
            out_q.served_level <= pend_lvl_q;
            out_q.status       <= pend_st_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_EXEC)
    else $error("accepted request did not enter execute");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_DONE)
    else $error("execute step did not advance");

  a_map_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && req_q.req_type != REQ_POST && any_nonempty) |-> sel_cnt != '0)
    else $error("occupancy map marks an empty level");

  a_write_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EXEC && req_q.req_type == REQ_POST && in_range && !lvl_full))
    else $error("slot write outside a successful post");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result presented without completing a request");
`endif

endmodule

### hdl/lwsrq_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Used for the slot store of the ready queue; no dependencies.
module lwsrq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
